// ----- rtl/core/rws_pkg.sv -----
// ============================================================================
// rws_pkg
// Shared types and constants of the refresh wake scheduler: sequencer
// states, configuration register indexes, field widths and reset values.
// ============================================================================
package rws_pkg;

    // Field widths
    localparam int FAIL_W  = 16;
    localparam int SEC_W   = 20;
    localparam int FLOOR_W = 39;
    localparam int CFG_W   = 39;
    localparam int IDX_W   = 3;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_LIVE_ENABLED = 3'd0;
    localparam logic [IDX_W-1:0] REG_DEVICE_PAIRED = 3'd1;
    localparam logic [IDX_W-1:0] REG_FIRST_RETRY = 3'd2;
    localparam logic [IDX_W-1:0] REG_MAX_RETRY = 3'd3;
    localparam logic [IDX_W-1:0] REG_EPOCH_FLOOR = 3'd4;

    // Register reset values
    localparam logic [SEC_W-1:0]   FIRST_RETRY_RST = 20'd900;
    localparam logic [SEC_W-1:0]   MAX_RETRY_RST   = 20'd14400;
    localparam logic [FLOOR_W-1:0] EPOCH_FLOOR_RST = 39'd1700000000;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_BACKOFF,
        S_CLASSIFY,
        S_ELAPSED,
        S_DUE,
        S_REMAIN,
        S_DONE
    } t_state;

endpackage

// ----- rtl/core/refresh_wake_scheduler_with_backoff_top.sv -----
// ============================================================================
// refresh_wake_scheduler_with_backoff_top
// Decides per request whether to refresh now and how long to arm the wake
// timer, using an exponential retry backoff after failures.
// ============================================================================
// One item is handled at a time. A disabled or unpaired block goes straight
// to the handover. An enabled block first runs the backoff, one step per
// cycle, when the failure count is nonzero. That is at most 20 steps: up to 19
// doublings before the delay reaches half the cap, plus the step that sees
// it. Then up to four compare/subtract steps follow for the clock checks,
// the elapsed time and the remaining time. A last step hands the result
// over. The backoff and compare steps all go through one shared signed
// subtractor. The block stalls its input until it has handed the result to
// the output register, so it cannot take a new item before it is through
// with the last one. While the output register still holds an untaken
// result, a finished item waits and the input stays stalled. The next item
// is accepted as soon as the result has moved to the output register.
// Configuration is written through a plain write port; the user must write
// it only while the block is idle, as the block does not enforce this.
module refresh_wake_scheduler_with_backoff_top
    import rws_pkg::*;
#(
    parameter int TIME_BITS = 40
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration write port
    input  logic                        i_cfg_wr_en,
    input  logic [IDX_W-1:0]            i_cfg_index,
    input  logic [CFG_W-1:0]            i_cfg_wdata,
    // request channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [FAIL_W-1:0]           i_failure_count,
    input  logic [SEC_W-1:0]            i_interval_seconds,
    input  logic signed [TIME_BITS-1:0] i_last_attempt_time,
    input  logic signed [TIME_BITS-1:0] i_now_time,
    input  logic                        i_timer_fired,
    // result channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_fetch_now,
    output logic [SEC_W-1:0]            o_timer_seconds
);

    // Width of the shared subtractor: covers signed times and the epoch floor
    localparam int MAXW = (TIME_BITS > FLOOR_W) ? TIME_BITS : FLOOR_W;
    localparam int UW   = MAXW + 2;

    // Configuration registers
    logic                r_live_enabled;
    logic                r_device_paired;
    logic [SEC_W-1:0]    r_first_retry;
    logic [SEC_W-1:0]    r_max_retry;
    logic [FLOOR_W-1:0]  r_epoch_floor;

    // Working registers
    t_state                      r_state, n_state;
    logic [FAIL_W-1:0]           r_failures, n_failures;
    logic [FAIL_W-1:0]           r_cnt, n_cnt;
    logic signed [TIME_BITS-1:0] r_last, n_last;
    logic signed [TIME_BITS-1:0] r_now, n_now;
    logic                        r_fired, n_fired;
    logic [SEC_W-1:0]            r_delay, n_delay;
    logic [SEC_W-1:0]            r_wait, n_wait;
    logic signed [TIME_BITS-1:0] r_elapsed, n_elapsed;
    logic                        r_fetch, n_fetch;
    logic [SEC_W-1:0]            r_timer, n_timer;

    // Output register
    logic                        r_out_valid, n_out_valid;
    logic                        r_out_fetch, n_out_fetch;
    logic [SEC_W-1:0]            r_out_timer, n_out_timer;

    // Shared subtractor
    logic signed [UW-1:0] w_a, w_b, w_diff;
    logic                 w_neg;

    logic w_accept;
    logic w_out_free;

    assign o_stall     = (r_state != S_IDLE);
    assign w_accept    = i_valid && !o_stall;
    assign w_out_free  = !r_out_valid || !i_stall;
    assign o_valid     = r_out_valid;
    assign o_fetch_now = r_out_fetch;
    assign o_timer_seconds = r_out_timer;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live_enabled  <= 1'b0;
            r_device_paired <= 1'b0;
            r_first_retry   <= FIRST_RETRY_RST;
            r_max_retry     <= MAX_RETRY_RST;
            r_epoch_floor   <= EPOCH_FLOOR_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_LIVE_ENABLED:  r_live_enabled  <= i_cfg_wdata[0];
                REG_DEVICE_PAIRED: r_device_paired <= i_cfg_wdata[0];
                REG_FIRST_RETRY:   r_first_retry   <= i_cfg_wdata[SEC_W-1:0];
                REG_MAX_RETRY:     r_max_retry     <= i_cfg_wdata[SEC_W-1:0];
                REG_EPOCH_FLOOR:   r_epoch_floor   <= i_cfg_wdata[FLOOR_W-1:0];
                default: ;
            endcase
        end
    end

    // Operand select for the shared subtractor
    always_comb begin
        w_a = '0;
        w_b = '0;
        case (r_state)
            S_BACKOFF: begin
                if (r_cnt == '0) begin
                    // final clamp: cap - delay
                    w_a = {{(UW-SEC_W){1'b0}}, r_max_retry};
                    w_b = {{(UW-SEC_W){1'b0}}, r_delay};
                end else begin
                    // saturation test: delay - cap/2
                    w_a = {{(UW-SEC_W){1'b0}}, r_delay};
                    w_b = {{(UW-SEC_W+1){1'b0}}, r_max_retry[SEC_W-1:1]};
                end
            end
            S_CLASSIFY: begin
                w_a = {{(UW-TIME_BITS){r_now[TIME_BITS-1]}}, r_now};
                w_b = {{(UW-FLOOR_W){1'b0}}, r_epoch_floor};
            end
            S_ELAPSED: begin
                w_a = {{(UW-TIME_BITS){r_now[TIME_BITS-1]}}, r_now};
                w_b = {{(UW-TIME_BITS){r_last[TIME_BITS-1]}}, r_last};
            end
            S_DUE: begin
                w_a = {{(UW-TIME_BITS){r_elapsed[TIME_BITS-1]}}, r_elapsed};
                w_b = {{(UW-SEC_W){1'b0}}, r_wait};
            end
            S_REMAIN: begin
                w_a = {{(UW-SEC_W){1'b0}}, r_wait};
                w_b = {{(UW-TIME_BITS){r_elapsed[TIME_BITS-1]}}, r_elapsed};
            end
            default: ;
        endcase
    end

    assign w_diff = w_a - w_b;
    assign w_neg  = w_diff[UW-1];

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_failures  <= n_failures;
        r_cnt       <= n_cnt;
        r_last      <= n_last;
        r_now       <= n_now;
        r_fired     <= n_fired;
        r_delay     <= n_delay;
        r_wait      <= n_wait;
        r_elapsed   <= n_elapsed;
        r_fetch     <= n_fetch;
        r_timer     <= n_timer;
        r_out_fetch <= n_out_fetch;
        r_out_timer <= n_out_timer;
    end

    // Next state and datapath
    always_comb begin
        n_state     = r_state;
        n_failures  = r_failures;
        n_cnt       = r_cnt;
        n_last      = r_last;
        n_now       = r_now;
        n_fired     = r_fired;
        n_delay     = r_delay;
        n_wait      = r_wait;
        n_elapsed   = r_elapsed;
        n_fetch     = r_fetch;
        n_timer     = r_timer;
        n_out_valid = r_out_valid;
        n_out_fetch = r_out_fetch;
        n_out_timer = r_out_timer;

        // result taken downstream
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_failures = i_failure_count;
                    n_last     = i_last_attempt_time;
                    n_now      = i_now_time;
                    n_fired    = i_timer_fired;
                    n_delay    = r_first_retry;
                    n_cnt      = i_failure_count - FAIL_W'(1);
                    n_fetch    = 1'b0;
                    n_timer    = '0;
                    n_wait     = i_interval_seconds;
                    if (!(r_live_enabled && r_device_paired)) begin
                        n_state = S_DONE;
                    end else if (i_failure_count == '0) begin
                        n_state = S_CLASSIFY;
                    end else begin
                        n_state = S_BACKOFF;
                    end
                end
            end
            // one doubling step per cycle
            S_BACKOFF: begin
                if (r_cnt == '0) begin
                    n_wait  = w_neg ? r_max_retry : r_delay;
                    n_state = S_CLASSIFY;
                end else if (!w_neg) begin
                    n_wait  = r_max_retry;
                    n_state = S_CLASSIFY;
                end else if (r_delay == '0) begin
                    n_wait  = '0;
                    n_state = S_CLASSIFY;
                end else begin
                    n_delay = {r_delay[SEC_W-2:0], 1'b0};
                    n_cnt   = r_cnt - FAIL_W'(1);
                end
            end
            // fired / never attempted / clock plausibility
            S_CLASSIFY: begin
                n_timer = r_wait;
                if (r_fired || r_last[TIME_BITS-1] || (r_last == '0)) begin
                    n_fetch = 1'b1;
                    n_state = S_DONE;
                end else if (r_now[TIME_BITS-1] || w_neg) begin
                    n_fetch = (r_failures == '0);
                    n_state = S_DONE;
                end else begin
                    n_state = S_ELAPSED;
                end
            end
            S_ELAPSED: begin
                n_elapsed = w_diff[TIME_BITS-1:0];
                n_state   = S_DUE;
            end
            // due check; a backwards clock keeps the full wait
            S_DUE: begin
                if (!w_neg) begin
                    n_fetch = 1'b1;
                    n_state = S_DONE;
                end else if (!r_elapsed[TIME_BITS-1] && (r_elapsed != '0)) begin
                    n_state = S_REMAIN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_REMAIN: begin
                n_timer = w_diff[SEC_W-1:0];
                n_state = S_DONE;
            end
            // hand the result to the output register
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_fetch = r_fetch;
                    n_out_timer = r_timer;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // an accepted item starts the sequencer
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("sequencer stayed idle after accepting an item");

    // remaining time is only taken for a positive elapsed time below the wait
    a_remain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REMAIN) |-> (!r_elapsed[TIME_BITS-1] && (r_elapsed != '0) && !w_neg))
        else $error("remaining time computed for an out-of-range elapsed time");

    // a finished item reaches the output register
    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && w_out_free) |=> (r_out_valid && (r_state == S_IDLE)))
        else $error("finished item did not reach the output register");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb
// Self-checking bench for the refresh wake scheduler. A local model of the
// wake decision predicts fetch_now and timer_seconds for every accepted item;
// a monitor compares each result against the oldest prediction. Directed
// items cover disabled/unpaired, backoff doubling and saturation, missing
// clock, due/not-due edges and zero retry delay; random traffic follows,
// mostly well-formed timing around the computed wait, under several register
// settings and three sender/receiver idling mixes.
// ============================================================================
module tb;
    import rws_pkg::*;

    localparam int TIME_BITS = 40;
    localparam longint TIME_MAX = (longint'(1) <<< (TIME_BITS - 1)) - 1;
    localparam longint TIME_MIN = -TIME_MAX - 1;
    localparam logic [FLOOR_W-1:0] FLOOR_MAX = '1;
    localparam int IDLE_LIMIT = 4000;
    localparam int MAX_PRINTED = 100;

    typedef struct {
        logic [FAIL_W-1:0]           failures;
        logic [SEC_W-1:0]            interval;
        logic signed [TIME_BITS-1:0] last;
        logic signed [TIME_BITS-1:0] now;
        logic                        fired;
    } t_wake_req;

    typedef struct {
        logic             fetch;
        logic [SEC_W-1:0] timer;
    } t_wake_res;

    // DUT ports
    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]            i_cfg_index = '0;
    logic [CFG_W-1:0]            i_cfg_wdata = '0;
    logic                        i_valid = 1'b0;
    logic                        o_stall;
    logic [FAIL_W-1:0]           i_failure_count = '0;
    logic [SEC_W-1:0]            i_interval_seconds = '0;
    logic signed [TIME_BITS-1:0] i_last_attempt_time = '0;
    logic signed [TIME_BITS-1:0] i_now_time = '0;
    logic                        i_timer_fired = 1'b0;
    logic                        o_valid;
    logic                        i_stall = 1'b0;
    logic                        o_fetch_now;
    logic [SEC_W-1:0]            o_timer_seconds;

    // Mirror of the configuration registers
    logic             cfg_live = 1'b0;
    logic             cfg_paired = 1'b0;
    logic [SEC_W-1:0] cfg_first = FIRST_RETRY_RST;
    logic [SEC_W-1:0] cfg_max = MAX_RETRY_RST;
    logic [FLOOR_W-1:0] cfg_floor = EPOCH_FLOOR_RST;

    t_wake_res wake_expect_q[$];
    int        err_count = 0;
    int        results_seen = 0;
    int        idle_cycles = 0;
    int        src_idle_pct = 0;
    int        sink_idle_pct = 0;

    refresh_wake_scheduler_with_backoff_top #(
        .TIME_BITS(TIME_BITS)
    ) u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_failure_count    (i_failure_count),
        .i_interval_seconds (i_interval_seconds),
        .i_last_attempt_time(i_last_attempt_time),
        .i_now_time         (i_now_time),
        .i_timer_fired      (i_timer_fired),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_fetch_now        (o_fetch_now),
        .o_timer_seconds    (o_timer_seconds)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Wake decision model
    // ------------------------------------------------------------------

    // Wait in seconds: interval when healthy, else doubled retry delay up to cap
    function automatic longint retry_wait(logic [FAIL_W-1:0] failures,
                                          logic [SEC_W-1:0] interval);
        longint dly;
        longint cap;
        if (failures == 0) return longint'(interval);
        dly = longint'(cfg_first);
        cap = longint'(cfg_max);
        for (int unsigned k = 1; k < failures; k++) begin
            if (dly >= cap / 2) return cap;
            if (dly == 0) break;
            dly = dly * 2;
        end
        return (dly > cap) ? cap : dly;
    endfunction

    function automatic t_wake_res predict_wake(t_wake_req r);
        t_wake_res res;
        longint    w;
        longint    last_v;
        longint    now_v;
        longint    elapsed;
        res.fetch = 1'b0;
        res.timer = '0;
        if (cfg_live && cfg_paired) begin
            w = retry_wait(r.failures, r.interval);
            last_v = r.last;
            now_v = r.now;
            res.timer = SEC_W'(w);
            if (r.fired || last_v <= 0) begin
                res.fetch = 1'b1;
            end else if (now_v < 0 || now_v < longint'(cfg_floor)) begin
                // no trustworthy clock: only a healthy device fetches
                res.fetch = (r.failures == 0);
            end else begin
                elapsed = now_v - last_v;
                if (elapsed >= w) begin
                    res.fetch = 1'b1;
                end else if (elapsed > 0) begin
                    res.timer = SEC_W'(w - elapsed);
                end
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Item builders
    // ------------------------------------------------------------------
    function automatic t_wake_req wake_req(int unsigned failures, int unsigned interval,
                                           longint last, longint now, bit fired);
        t_wake_req r;
        r.failures = FAIL_W'(failures);
        r.interval = SEC_W'(interval);
        r.last = TIME_BITS'(last);
        r.now = TIME_BITS'(now);
        r.fired = fired;
        return r;
    endfunction

    // Well-formed: now mostly at or above the floor, last attempt near the wait
    function automatic t_wake_req random_wake(bit well_formed);
        t_wake_req r;
        longint    w;
        longint    now_v;
        longint    gap;
        r.failures = ($urandom_range(3) == 0) ? FAIL_W'($urandom)
                                              : FAIL_W'($urandom_range(24));
        r.interval = ($urandom_range(3) == 0) ? SEC_W'($urandom_range(604800))
                                              : SEC_W'($urandom_range(4000));
        r.fired = ($urandom_range(7) == 0);
        r.last = TIME_BITS'({$urandom, $urandom});
        r.now = TIME_BITS'({$urandom, $urandom});
        if (well_formed) begin
            w = retry_wait(r.failures, r.interval);
            if ($urandom_range(7) == 0)
                now_v = longint'(cfg_floor) - 1 - longint'($urandom_range(100));
            else
                now_v = longint'(cfg_floor) + longint'($urandom_range(1000000));
            if (now_v > TIME_MAX) now_v = TIME_MAX;
            case ($urandom_range(6))
                0: gap = w;
                1: gap = w - 1;
                2: gap = w + 1;
                3: gap = -longint'($urandom_range(5000));
                4: gap = longint'($urandom);
                default: gap = longint'($urandom_range(int'(w)));
            endcase
            r.now = TIME_BITS'(now_v);
            r.last = TIME_BITS'(now_v - gap);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver side
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        if (err_count < MAX_PRINTED)
            $display("[%0t] mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            REG_LIVE_ENABLED:  cfg_live = val[0];
            REG_DEVICE_PAIRED: cfg_paired = val[0];
            REG_FIRST_RETRY:   cfg_first = val[SEC_W-1:0];
            REG_MAX_RETRY:     cfg_max = val[SEC_W-1:0];
            REG_EPOCH_FLOOR:   cfg_floor = val[FLOOR_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Send one item, with random idle cycles ahead of it
    task automatic send_wake(input t_wake_req r);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        i_valid <= 1'b1;
        i_failure_count <= r.failures;
        i_interval_seconds <= r.interval;
        i_last_attempt_time <= r.last;
        i_now_time <= r.now;
        i_timer_fired <= r.fired;
        do @(posedge i_clk); while (o_stall);
        wake_expect_q.push_back(predict_wake(r));
    endtask

    // Hold off the sender until every outstanding result has come back
    task automatic drain_results();
        i_valid <= 1'b0;
        while (wake_expect_q.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Result monitor and receiver stalls
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_wake_res exp_res;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (wake_expect_q.size() == 0) begin
                report_mismatch("result with no request pending");
            end else begin
                exp_res = wake_expect_q.pop_front();
                if (o_fetch_now !== exp_res.fetch)
                    report_mismatch($sformatf("result %0d fetch_now %b, expected %b",
                        results_seen, o_fetch_now, exp_res.fetch));
                if (o_timer_seconds !== exp_res.timer)
                    report_mismatch($sformatf("result %0d timer_seconds %0d, expected %0d",
                        results_seen, o_timer_seconds, exp_res.timer));
            end
        end
        i_stall <= ($urandom_range(99) < sink_idle_pct);
    end

    // Watchdog: too long without any handshake or register write
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_wr_en)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Disabled or unpaired: no fetch, no timer
    task automatic test_disabled();
        send_wake(wake_req(0, 604800, 100, 1800000000, 1'b0));
        drain_results();
        write_reg(REG_LIVE_ENABLED, 1);
        send_wake(wake_req(3, 5, 0, 0, 1'b1));
        drain_results();
        write_reg(REG_LIVE_ENABLED, 0);
        write_reg(REG_DEVICE_PAIRED, 1);
        send_wake(wake_req(65535, 0, -1, -1, 1'b1));
        drain_results();
    endtask

    // Reset values of retry delay, cap and floor
    task automatic test_reset_backoff();
        longint fl;
        fl = longint'(EPOCH_FLOOR_RST);
        write_reg(REG_LIVE_ENABLED, 1);
        send_wake(wake_req(1, 7, 1, 1, 1'b1));
        send_wake(wake_req(2, 7, 1, 1, 1'b1));
        send_wake(wake_req(5, 7, 1, 1, 1'b1));
        send_wake(wake_req(0, 604800, 1, 1, 1'b1));
        // just below the floor: no usable clock
        send_wake(wake_req(0, 60, 5, fl - 1, 1'b0));
        send_wake(wake_req(3, 60, 5, fl - 1, 1'b0));
        // exactly at the floor and due
        send_wake(wake_req(0, 100, fl - 100, fl, 1'b0));
    endtask

    // Due, not due, clock backwards and extreme times
    task automatic test_timing_edges();
        longint t0;
        t0 = 64'd1800000000;
        send_wake(wake_req(0, 3600, t0 - 10, t0, 1'b0));
        send_wake(wake_req(0, 3600, t0 - 3599, t0, 1'b0));
        send_wake(wake_req(0, 3600, t0 - 3600, t0, 1'b0));
        send_wake(wake_req(0, 3600, t0 + 50, t0, 1'b0));
        send_wake(wake_req(0, 0, t0, t0, 1'b0));
        send_wake(wake_req(4, 3600, TIME_MIN, TIME_MAX, 1'b0));
        send_wake(wake_req(1, 3600, TIME_MAX, TIME_MAX, 1'b0));
        send_wake(wake_req(2, 3600, 12345, -1, 1'b0));
        send_wake(wake_req(0, 3600, 12345, TIME_MIN, 1'b0));
        send_wake(wake_req(65535, 1, t0 - 1, t0, 1'b0));
    endtask

    // Zero first retry, cap of one and floor extremes
    task automatic test_retry_extremes();
        drain_results();
        write_reg(REG_FIRST_RETRY, 0);
        write_reg(REG_MAX_RETRY, 1);
        send_wake(wake_req(1, 9, 1, 1, 1'b1));
        send_wake(wake_req(2, 9, 1, 1, 1'b1));
        drain_results();
        write_reg(REG_MAX_RETRY, 604800);
        write_reg(REG_EPOCH_FLOOR, 0);
        send_wake(wake_req(2, 9, 1, 1, 1'b1));
        send_wake(wake_req(1, 9, 100, 0, 1'b0));
        drain_results();
        write_reg(REG_FIRST_RETRY, 604800);
        write_reg(REG_EPOCH_FLOOR, FLOOR_MAX);
        send_wake(wake_req(2, 9, 1, 1, 1'b1));
        send_wake(wake_req(1, 9, 100, TIME_MAX - 1, 1'b0));
        send_wake(wake_req(1, 9, TIME_MAX - 604799, TIME_MAX, 1'b0));
        drain_results();
    endtask

    // Random traffic in segments, each under a fresh register setting
    task automatic test_random_traffic(input int n_items, input int src_pct,
                                       input int sink_pct);
        int               sent;
        int               seg_len;
        logic [CFG_W-1:0] val;
        src_idle_pct = src_pct;
        sink_idle_pct = sink_pct;
        sent = 0;
        while (sent < n_items) begin
            drain_results();
            val = CFG_W'({$urandom, $urandom});
            val[0] = ($urandom_range(9) != 0);
            write_reg(REG_LIVE_ENABLED, val);
            val = CFG_W'({$urandom, $urandom});
            val[0] = ($urandom_range(9) != 0);
            write_reg(REG_DEVICE_PAIRED, val);
            val = CFG_W'({$urandom, $urandom});
            case ($urandom_range(5))
                0: val[SEC_W-1:0] = '0;
                1: val[SEC_W-1:0] = SEC_W'(1);
                2: val[SEC_W-1:0] = SEC_W'(604800);
                default: val[SEC_W-1:0] = SEC_W'($urandom_range(5000, 1));
            endcase
            write_reg(REG_FIRST_RETRY, val);
            val = CFG_W'({$urandom, $urandom});
            case ($urandom_range(4))
                0: val[SEC_W-1:0] = SEC_W'(1);
                1: val[SEC_W-1:0] = SEC_W'(604800);
                default: val[SEC_W-1:0] = SEC_W'($urandom_range(604800, 1));
            endcase
            write_reg(REG_MAX_RETRY, val);
            case ($urandom_range(4))
                0: val = '0;
                1: val = FLOOR_MAX;
                2: val = EPOCH_FLOOR_RST;
                default: val = CFG_W'({$urandom, $urandom});
            endcase
            write_reg(REG_EPOCH_FLOOR, val);
            seg_len = $urandom_range(140, 60);
            for (int k = 0; k < seg_len && sent < n_items; k++) begin
                send_wake(random_wake($urandom_range(4) != 0));
                sent++;
                if ($urandom_range(59) == 0) drain_results();
            end
        end
    endtask

    initial begin
        src_idle_pct = 37;
        sink_idle_pct = 45;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_disabled();
        test_reset_backoff();
        test_timing_edges();
        test_retry_extremes();
        test_random_traffic(500, 37, 45);
        test_random_traffic(500, 45, 37);
        test_random_traffic(500, 0, 0);

        drain_results();
        repeat (40) @(posedge i_clk);
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
